FILE: hw/rtl/can_bts_pkg.sv
// ----------------------------------------------------------------------------
// CAN bit timing search package
// Widths, search limits, the result record and the timing word packing shared
// by the bit timing search modules.
// ----------------------------------------------------------------------------
package can_bts_pkg;

  localparam int CLOCK_W = 27;
  localparam int BAUD_W  = 20;
  localparam int DIV_W   = 4;
  localparam int QM1_W   = 5;
  localparam int SM3_W   = 4;
  localparam int WORD_W  = 15;
  localparam int STEP_W  = 10;
  localparam int PROD_W  = 14;

  localparam logic [DIV_W-1:0]   DIV_LAST    = 4'd15;
  localparam logic [QM1_W-1:0]   QM1_LAST    = 5'd31;
  localparam logic [SM3_W-1:0]   SM3_LAST    = 4'd14;
  localparam logic [1:0]         SJW_MAX     = 2'd3;
  localparam logic [CLOCK_W-1:0] CLOCK_RESET = 27'd48000000;

  typedef struct packed {
    logic              found;
    logic [DIV_W-1:0]  clock_divider;
    logic [WORD_W-1:0] timing_word;
  } can_bts_result_t;

  // Packs quanta minus one and the segment count minus three into the timing word.
  function automatic logic [WORD_W-1:0] timing_pack(logic [QM1_W-1:0] qm1,
                                                    logic [SM3_W-1:0] sm3);
    logic [2:0] t1;
    logic [3:0] t2;
    logic [1:0] sjw;
    t1  = sm3[3:1];
    t2  = sm3 - {1'b0, t1};
    sjw = (t1 > 3'd3) ? SJW_MAX : t1[1:0];
    return {t2[2:0], 1'b0, t1, sjw, 1'b0, qm1};
  endfunction

endpackage

FILE: hw/rtl/can_bts_div.sv
// ----------------------------------------------------------------------------
// CAN bit timing divider
// Restoring divider that forms clocks per bit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module can_bts_div import can_bts_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [CLOCK_W-1:0] dividend,
  input  logic [BAUD_W-1:0]  divisor,
  output logic               done,
  output logic [CLOCK_W-1:0] quotient
);

  localparam logic [4:0] STEP_LAST = 5'(CLOCK_W - 1);

  logic              busy;
  logic [4:0]        count;
  logic [BAUD_W-1:0] divisor_q;
  logic [BAUD_W-1:0] rem;
  logic [BAUD_W+1:0] trial;
  logic              borrow;

  assign trial    = {1'b0, rem, quotient[CLOCK_W-1]} - {2'b00, divisor_q};
  assign borrow   = trial[BAUD_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && count == STEP_LAST) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      count     <= '0;
      divisor_q <= divisor;
      rem       <= '0;
      quotient  <= dividend;
    end else if (busy) begin
      count    <= count + 5'd1;
      rem      <= borrow ? {rem[BAUD_W-2:0], quotient[CLOCK_W-1]} : trial[BAUD_W-1:0];
      quotient <= {quotient[CLOCK_W-2:0], ~borrow};
    end
  end

endmodule

FILE: hw/rtl/can_bts_search.sv
// ----------------------------------------------------------------------------
// CAN bit timing search sequencer
// Walks divider, quanta and segment counts in order, building each candidate
// product with one shared adder, to the first exact match or last candidate.
// ----------------------------------------------------------------------------
module can_bts_search import can_bts_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [CLOCK_W-1:0] cpb,
  output logic               done,
  output can_bts_result_t    result
);

  logic              busy;
  logic              phase_load;
  logic [DIV_W-1:0]  d;
  logic [QM1_W-1:0]  qm1;
  logic [SM3_W-1:0]  sm3;
  logic [STEP_W-1:0] step;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] add_a;
  logic [PROD_W-1:0] add_b;
  logic [PROD_W-1:0] add_sum;
  logic              match;
  logic              last_s;
  logic              last_q;
  logic              last_d;

  assign match  = (cpb == {{(CLOCK_W-PROD_W){1'b0}}, prod});
  assign last_s = (sm3 == SM3_LAST);
  assign last_q = (qm1 == QM1_LAST);
  assign last_d = (d == DIV_LAST);

  // The one adder: next product, next step, or three times the step.
  always_comb begin
    if (phase_load) begin
      add_a = {{(PROD_W-STEP_W){1'b0}}, step};
      add_b = {{(PROD_W-STEP_W-1){1'b0}}, step, 1'b0};
    end else if (!last_s) begin
      add_a = prod;
      add_b = {{(PROD_W-STEP_W){1'b0}}, step};
    end else if (!last_q) begin
      add_a = {{(PROD_W-STEP_W){1'b0}}, step};
      add_b = {{(PROD_W-DIV_W){1'b0}}, d} + 14'd1;
    end else begin
      add_a = {{(PROD_W-DIV_W){1'b0}}, d};
      add_b = 14'd2;
    end
  end

  assign add_sum = add_a + add_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      done       <= 1'b0;
      phase_load <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy       <= 1'b1;
        phase_load <= 1'b0;
      end else if (busy) begin
        if (phase_load) begin
          phase_load <= 1'b0;
        end else if (match || (last_s && last_q && last_d)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else if (last_s) begin
          phase_load <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d    <= '0;
      qm1  <= '0;
      sm3  <= '0;
      step <= 10'd1;
      prod <= 14'd3;
    end else if (busy) begin
      if (phase_load) begin
        prod <= add_sum;
      end else if (match) begin
        result.found         <= 1'b1;
        result.clock_divider <= d;
        result.timing_word   <= timing_pack(qm1, sm3);
      end else if (!last_s) begin
        sm3  <= sm3 + 4'd1;
        prod <= add_sum;
      end else if (!last_q) begin
        qm1  <= qm1 + 5'd1;
        sm3  <= '0;
        step <= add_sum[STEP_W-1:0];
      end else if (!last_d) begin
        d    <= d + 4'd1;
        qm1  <= '0;
        sm3  <= '0;
        step <= add_sum[STEP_W-1:0];
      end else begin
        result <= '0;
      end
    end
  end

endmodule

FILE: hw/rtl/can_bit_timing_search.sv
// ----------------------------------------------------------------------------
// CAN bit timing search
// Finds the first exact divider, quanta and segment combination for a
// requested bit rate and returns the divider and the packed timing word.
// ----------------------------------------------------------------------------
// Channel    Dir   Payload
// s_*        in    tdata[19:0] bit_rate
// m_*        out   tuser found; tdata[3:0] clock_divider, [18:4] timing_word
// APB        in    register 0 at address 0: clock_hz
//
// A nonzero rate is first divided into clocks per bit, then searched on one
// adder (15 segment checks per quanta value and a product load between values).
// A zero rate skips both and goes straight to the wait state; from the wait
// state the result is registered onto the output when the output is free.
// s_tready is high only while the block is idle; a result waiting on m_tready
// holds the next one back. Reset sets clock_hz to 48000000 and empties the block.
// ----------------------------------------------------------------------------
module can_bit_timing_search import can_bts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [19:0] bit_rate
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [3:0] clock_divider, [18:4] timing_word
  output logic        m_tuser,   // found
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIV    = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;
  localparam logic [1:0] ST_WAIT   = 2'd3;

  localparam logic REG_CLOCK_HZ = 1'b0;

  logic [1:0]         state;
  logic [CLOCK_W-1:0] clock_hz;
  logic               zero_rate;
  logic               in_beat;
  logic               rate_zero_in;
  logic               div_start;
  logic               div_done;
  logic [CLOCK_W-1:0] cpb;
  logic               search_done;
  can_bts_result_t    search_result;
  can_bts_result_t    out_result;
  logic               out_load;

  assign pready       = 1'b1;
  assign prdata       = (paddr[2] == REG_CLOCK_HZ) ? {5'd0, clock_hz} : 32'd0;
  assign s_tready     = (state == ST_IDLE);
  assign in_beat      = s_tvalid && s_tready;
  assign rate_zero_in = (s_tdata[BAUD_W-1:0] == '0);
  assign div_start    = in_beat && !rate_zero_in;
  assign out_load     = (state == ST_WAIT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= CLOCK_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CLOCK_HZ) begin
      clock_hz <= pwdata[CLOCK_W-1:0];
    end
  end

  can_bts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (clock_hz),
    .divisor  (s_tdata[BAUD_W-1:0]),
    .done     (div_done),
    .quotient (cpb)
  );

  can_bts_search u_search (
    .clk    (clk),
    .rst    (rst),
    .start  (div_done),
    .cpb    (cpb),
    .done   (search_done),
    .result (search_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_beat) begin
            state <= rate_zero_in ? ST_WAIT : ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (search_done) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      zero_rate <= rate_zero_in;
    end
    if (out_load) begin
      out_result <= zero_rate ? '0 : search_result;
    end
  end

  assign m_tuser = out_result.found;
  assign m_tdata = {5'd0, out_result.timing_word, out_result.clock_divider};

endmodule

FILE: hw/rtl/can_bts_checker.sv
// ----------------------------------------------------------------------------
// CAN bit timing search checker
// Port-level checks on result beats and input acceptance, bound to the top.
// ----------------------------------------------------------------------------
module can_bts_sva (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tuser
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // The block works on one item at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is in flight");

  // A miss carries all-zero fields.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 24'd0)
    else $error("miss with nonzero fields");

  // The jump width is tseg1 clamped to three.
  a_sjw: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |->
      (m_tdata[15:12] >= 4'd3) ? (m_tdata[11:10] == 2'd3)
                               : (m_tdata[11:10] == m_tdata[13:12]))
    else $error("jump width does not follow tseg1");

  // tseg2 equals tseg1 or exceeds it by one, and tseg1 stays below eight.
  a_split: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> !m_tdata[15] &&
      ((m_tdata[18:16] == m_tdata[14:12]) ||
       (m_tdata[18:16] == m_tdata[14:12] + 3'd1)))
    else $error("segment split is not balanced");

endmodule

bind can_bit_timing_search can_bts_sva u_checker (.*);
